// ===== src/svgplt_pkg.sv =====
`default_nettype none

package svgplt_pkg;

  // Fraction digits kept per number; later digits are dropped.
  localparam int FRAC_DIGITS = 5;
  localparam int FRAC_W      = $clog2(10 ** FRAC_DIGITS);
  // The digit counter and the scale tables cover up to six kept digits.
  localparam int CNT_W       = 3;
  localparam int INT_W       = 16;
  localparam int REC_W       = 38;
  localparam int PROD_W      = FRAC_W + REC_W;
  localparam int SH_W        = 6;
  localparam int QW          = 17;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W      = $clog2(FIFO_DEPTH + 1);

  // Character codes.
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_V     = 8'h56;
  localparam logic [7:0] CH_LH    = 8'h68;
  localparam logic [7:0] CH_LV    = 8'h76;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CMD_NONE = 8'h00;

  // Fraction scaling: q = (frac * REC + HALF) >> SH equals the fraction
  // times 65536 over ten to the digit count, rounded half up. The reciprocal
  // is rounded up and the shift is wide enough that the error never moves
  // the result across an integer.
  localparam logic [REC_W-1:0] REC_TAB [8] = '{
    REC_W'(0),
    REC_W'(((64'd1 << 24) + 64'd9) / 64'd10),
    REC_W'(((64'd1 << 31) + 64'd99) / 64'd100),
    REC_W'(((64'd1 << 37) + 64'd999) / 64'd1000),
    REC_W'(((64'd1 << 44) + 64'd9999) / 64'd10000),
    REC_W'(((64'd1 << 51) + 64'd99999) / 64'd100000),
    REC_W'(((64'd1 << 57) + 64'd999999) / 64'd1000000),
    REC_W'(0)
  };

  localparam logic [SH_W-1:0] SH_TAB [8] = '{
    SH_W'(0), SH_W'(8), SH_W'(15), SH_W'(21), SH_W'(28), SH_W'(35), SH_W'(41), SH_W'(0)
  };

  localparam logic [PROD_W-1:0] HALF_TAB [8] = '{
    PROD_W'(0),
    PROD_W'(64'd1 << 7),
    PROD_W'(64'd1 << 14),
    PROD_W'(64'd1 << 20),
    PROD_W'(64'd1 << 27),
    PROD_W'(64'd1 << 34),
    PROD_W'(64'd1 << 40),
    PROD_W'(0)
  };

  typedef struct packed {
    logic [7:0] path_byte;
    logic       end_of_path;
  } tok_in_t;

  typedef struct packed {
    logic signed [31:0] x_from;
    logic signed [31:0] y_from;
    logic signed [31:0] x_to;
    logic signed [31:0] y_to;
    logic               last_of_run;
  } seg_out_t;

  typedef struct packed {
    logic dig;
    logic bad;
    logic dot;
    logic neg;
    logic in_tok;
  } tok_flags_t;

  // A finished number in raw digit form, plus what the byte does to commands.
  typedef struct packed {
    logic              num_vld;
    logic              neg;
    logic [INT_W-1:0]  int_mag;
    logic [FRAC_W-1:0] frac;
    logic [CNT_W-1:0]  dcnt;
    logic              letter;
    logic [7:0]        code;
    logic              last;
  } a_ev_t;

  typedef struct packed {
    logic              num_vld;
    logic              neg;
    logic [INT_W-1:0]  int_mag;
    logic [PROD_W-1:0] prod;
    logic [CNT_W-1:0]  dcnt;
    logic              letter;
    logic [7:0]        code;
    logic              last;
  } b1_ev_t;

  typedef struct packed {
    logic               num_vld;
    logic signed [31:0] val;
    logic               letter;
    logic [7:0]         code;
    logic               last;
  } b2_ev_t;

  typedef struct packed {
    logic signed [31:0] cur_x;
    logic signed [31:0] cur_y;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
  } pt_t;

  typedef struct packed {
    logic               emit;
    logic signed [31:0] to_x;
    logic signed [31:0] to_y;
    pt_t                pt;
  } exec_t;

endpackage

`default_nettype wire

// ===== src/svg_path_line_tokenizer.sv =====
`default_nettype none

// Throughput: one path byte per cycle unless held; a byte closing a command and the path
// at once yields two segments, which leave the output queue at one per unstalled cycle.
// The pipeline (tokenizer, fraction multiply, rounding, command stage) holds whenever the
// four-entry output queue has fewer than two free entries.
// Synchronous active-low reset clears all control state at once; no clearing pass.
module svg_path_line_tokenizer
  import svgplt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire tok_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output seg_out_t      out_data
);

  // ---------------------------------------------------------------------------
  // Pipeline control. Every stage moves together; the command stage may push
  // two segments into the queue, so the whole pipe advances only while two
  // entries are free.
  // ---------------------------------------------------------------------------
  logic [FCNT_W-1:0] fcnt_r;
  logic              adv;
  logic              accept;

  assign adv      = (fcnt_r <= FCNT_W'(FIFO_DEPTH - 2));
  assign in_stall = ~adv;
  assign accept   = in_valid & adv;

  // ---------------------------------------------------------------------------
  // Stage A: byte classification and digit accumulation. The tokenizer state
  // lives here; a finished number is passed on in raw digit form.
  // ---------------------------------------------------------------------------
  logic [INT_W-1:0]  int_r, int_nxt;
  logic [FRAC_W-1:0] frac_r, frac_nxt;
  logic [CNT_W-1:0]  dcnt_r, dcnt_nxt;
  tok_flags_t        flags_r, flags_nxt;

  logic [7:0]        b;
  logic [7:0]        b_off;
  logic [3:0]        digit;
  logic              is_alpha, is_sign, is_digit, is_dot;
  logic              end_pre;
  logic              pre_ok, post_ok;
  logic [INT_W+3:0]  int_mul;
  logic [FRAC_W+3:0] frac_mul;
  a_ev_t             a_nxt;

  assign b        = in_data.path_byte;
  assign b_off    = b - CH_0;
  assign digit    = b_off[3:0];
  assign is_alpha = ((b >= CH_UA) && (b <= CH_Z)) || ((b >= CH_LA) && (b <= CH_LZ));
  assign is_sign  = (b == CH_MINUS) || (b == CH_PLUS);
  assign is_digit = (b >= CH_0) && (b <= CH_9);
  assign is_dot   = (b == CH_DOT);

  assign int_mul  = {1'b0, int_r, 3'b000} + {3'b000, int_r, 1'b0} + (INT_W+4)'(digit);
  assign frac_mul = {1'b0, frac_r, 3'b000} + {3'b000, frac_r, 1'b0} + (FRAC_W+4)'(digit);

  always_comb begin
    int_nxt   = int_r;
    frac_nxt  = frac_r;
    dcnt_nxt  = dcnt_r;
    flags_nxt = flags_r;
    end_pre   = 1'b0;
    priority if (is_alpha) begin
      end_pre   = 1'b1;
      int_nxt   = '0;
      frac_nxt  = '0;
      dcnt_nxt  = '0;
      flags_nxt = '0;
    end else if (is_sign) begin
      end_pre          = 1'b1;
      int_nxt          = '0;
      frac_nxt         = '0;
      dcnt_nxt         = '0;
      flags_nxt        = '0;
      flags_nxt.in_tok = 1'b1;
      flags_nxt.neg    = (b == CH_MINUS);
    end else if (is_digit) begin
      flags_nxt.in_tok = 1'b1;
      flags_nxt.dig    = 1'b1;
      if (flags_r.dot) begin
        if (dcnt_r < CNT_W'(FRAC_DIGITS)) begin
          frac_nxt = frac_mul[FRAC_W-1:0];
          dcnt_nxt = dcnt_r + CNT_W'(1);
        end
      end else begin
        int_nxt = (int_mul > (INT_W+4)'({INT_W{1'b1}})) ? {INT_W{1'b1}} : int_mul[INT_W-1:0];
      end
    end else if (is_dot) begin
      if (flags_r.dot) begin
        flags_nxt.bad = 1'b1;
      end
      flags_nxt.in_tok = 1'b1;
      flags_nxt.dot    = 1'b1;
    end else begin
      end_pre   = 1'b1;
      int_nxt   = '0;
      frac_nxt  = '0;
      dcnt_nxt  = '0;
      flags_nxt = '0;
    end
  end

  assign pre_ok  = flags_r.in_tok & flags_r.dig & ~flags_r.bad;
  assign post_ok = flags_nxt.in_tok & flags_nxt.dig & ~flags_nxt.bad;

  // At most one number ends per byte: either the byte itself ends the
  // running token, or the end marker ends the token the byte left behind.
  always_comb begin
    a_nxt.num_vld = end_pre ? pre_ok : (in_data.end_of_path & post_ok);
    a_nxt.neg     = end_pre ? flags_r.neg : flags_nxt.neg;
    a_nxt.int_mag = end_pre ? int_r : int_nxt;
    a_nxt.frac    = end_pre ? frac_r : frac_nxt;
    a_nxt.dcnt    = end_pre ? dcnt_r : dcnt_nxt;
    a_nxt.letter  = is_alpha;
    a_nxt.code    = b;
    a_nxt.last    = in_data.end_of_path;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_r   <= '0;
      frac_r  <= '0;
      dcnt_r  <= '0;
      flags_r <= '0;
    end else if (accept) begin
      if (in_data.end_of_path) begin
        int_r   <= '0;
        frac_r  <= '0;
        dcnt_r  <= '0;
        flags_r <= '0;
      end else begin
        int_r   <= int_nxt;
        frac_r  <= frac_nxt;
        dcnt_r  <= dcnt_nxt;
        flags_r <= flags_nxt;
      end
    end
  end

  logic  a_vld_r;
  a_ev_t a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r <= a_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B1: fraction digits times the scaled reciprocal of the digit weight.
  // ---------------------------------------------------------------------------
  logic              b1_vld_r;
  b1_ev_t            b1_r;
  b1_ev_t            b1_nxt;
  logic [PROD_W-1:0] mul_a, mul_b;

  assign mul_a = PROD_W'(a_r.frac);
  assign mul_b = PROD_W'(REC_TAB[a_r.dcnt]);

  always_comb begin
    b1_nxt.num_vld = a_r.num_vld;
    b1_nxt.neg     = a_r.neg;
    b1_nxt.int_mag = a_r.int_mag;
    b1_nxt.prod    = mul_a * mul_b;
    b1_nxt.dcnt    = a_r.dcnt;
    b1_nxt.letter  = a_r.letter;
    b1_nxt.code    = a_r.code;
    b1_nxt.last    = a_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r <= 1'b0;
    end else if (adv) begin
      b1_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_r <= b1_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B2: rounding shift, integer part, sign and saturation to Q16.16.
  // ---------------------------------------------------------------------------
  logic              b2_vld_r;
  b2_ev_t            b2_r;
  b2_ev_t            b2_nxt;
  logic [PROD_W:0]   rsum;
  logic [PROD_W:0]   rshift;
  logic [QW-1:0]     q;
  logic [32:0]       mag;
  logic [32:0]       mag_neg;
  logic signed [31:0] num_val;

  assign rsum    = {1'b0, b1_r.prod} + {1'b0, HALF_TAB[b1_r.dcnt]};
  assign rshift  = rsum >> SH_TAB[b1_r.dcnt];
  assign q       = rshift[QW-1:0];
  assign mag     = {1'b0, b1_r.int_mag, 16'h0000} + 33'(q);
  assign mag_neg = ~mag + 33'd1;

  always_comb begin
    if (b1_r.neg) begin
      num_val = (mag >= 33'h080000000) ? 32'sh80000000 : signed'(mag_neg[31:0]);
    end else begin
      num_val = (mag > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : signed'(mag[31:0]);
    end
  end

  always_comb begin
    b2_nxt.num_vld = b1_r.num_vld;
    b2_nxt.val     = num_val;
    b2_nxt.letter  = b1_r.letter;
    b2_nxt.code    = b1_r.code;
    b2_nxt.last    = b1_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_vld_r <= 1'b0;
    end else if (adv) begin
      b2_vld_r <= b1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b2_r <= b2_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: command state. The new number is filed first, then a letter runs
  // the pending command and takes its place, then the end marker runs whatever
  // command is pending. Both runs are evaluated in the same cycle.
  // ---------------------------------------------------------------------------
  logic [7:0]         cmd_r;
  logic [1:0]         ncnt_r;
  logic signed [31:0] first_r, second_r;
  pt_t                pt_r;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b2);
    logic [32:0] s;
    s = {a[31], a} + {b2[31], b2};
    if (s[32] != s[31]) begin
      sat_add = s[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      sat_add = signed'(s[31:0]);
    end
  endfunction

  function automatic exec_t run_cmd(input logic [7:0]         cmd,
                                    input logic [1:0]         cnt,
                                    input logic signed [31:0] n1,
                                    input logic signed [31:0] n2,
                                    input pt_t                p);
    exec_t r;
    r.emit = 1'b0;
    r.to_x = p.cur_x;
    r.to_y = p.cur_y;
    r.pt   = p;
    unique case (cmd)
      CH_M: begin
        if (cnt >= 2'd2) begin
          r.pt.cur_x   = n1;
          r.pt.cur_y   = n2;
          r.pt.start_x = n1;
          r.pt.start_y = n2;
        end
      end
      CH_L: begin
        r.emit = (cnt >= 2'd2);
        r.to_x = n1;
        r.to_y = n2;
      end
      CH_H: begin
        r.emit = (cnt >= 2'd1);
        r.to_x = n1;
      end
      CH_V: begin
        r.emit = (cnt >= 2'd1);
        r.to_y = n1;
      end
      CH_LH: begin
        r.emit = (cnt >= 2'd1);
        r.to_x = sat_add(p.cur_x, n1);
      end
      CH_LV: begin
        r.emit = (cnt >= 2'd1);
        r.to_y = sat_add(p.cur_y, n1);
      end
      CH_Z, CH_LZ: begin
        r.emit = 1'b1;
        r.to_x = p.start_x;
        r.to_y = p.start_y;
      end
      default: begin
        r.emit = 1'b0;
      end
    endcase
    if (r.emit) begin
      r.pt.cur_x = r.to_x;
      r.pt.cur_y = r.to_y;
    end
    run_cmd = r;
  endfunction

  logic [1:0]         cnt0, cnt1;
  logic signed [31:0] first0, second0, first1, second1;
  logic [7:0]         cmd1;
  pt_t                pt1;
  exec_t              r1, r2;
  logic               e1, e2;
  logic               c_fire;
  seg_out_t           seg1, seg2;

  assign c_fire = b2_vld_r & adv;

  always_comb begin
    cnt0    = ncnt_r;
    first0  = first_r;
    second0 = second_r;
    if (b2_r.num_vld) begin
      if (ncnt_r == 2'd0) begin
        first0 = b2_r.val;
      end
      if (ncnt_r == 2'd1) begin
        second0 = b2_r.val;
      end
      if (ncnt_r != 2'd2) begin
        cnt0 = ncnt_r + 2'd1;
      end
    end
  end

  assign r1      = run_cmd(cmd_r, cnt0, first0, second0, pt_r);
  assign e1      = b2_r.letter & r1.emit;
  assign pt1     = b2_r.letter ? r1.pt : pt_r;
  assign cmd1    = b2_r.letter ? b2_r.code : cmd_r;
  assign cnt1    = b2_r.letter ? 2'd0 : cnt0;
  assign first1  = b2_r.letter ? 32'sd0 : first0;
  assign second1 = b2_r.letter ? 32'sd0 : second0;
  assign r2      = run_cmd(cmd1, cnt1, first1, second1, pt1);
  assign e2      = b2_r.last & r2.emit;

  always_comb begin
    seg1.x_from      = pt_r.cur_x;
    seg1.y_from      = pt_r.cur_y;
    seg1.x_to        = r1.to_x;
    seg1.y_to        = r1.to_y;
    seg1.last_of_run = ~e2;
    seg2.x_from      = pt1.cur_x;
    seg2.y_from      = pt1.cur_y;
    seg2.x_to        = r2.to_x;
    seg2.y_to        = r2.to_y;
    seg2.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r    <= CMD_NONE;
      ncnt_r   <= '0;
      first_r  <= '0;
      second_r <= '0;
      pt_r     <= '0;
    end else if (c_fire) begin
      if (b2_r.last) begin
        cmd_r    <= CMD_NONE;
        ncnt_r   <= '0;
        first_r  <= '0;
        second_r <= '0;
        pt_r     <= '0;
      end else begin
        cmd_r    <= cmd1;
        ncnt_r   <= cnt1;
        first_r  <= first1;
        second_r <= second1;
        pt_r     <= pt1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output queue: four entries, up to two writes and one read per cycle.
  // ---------------------------------------------------------------------------
  seg_out_t           fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic               push1, push2, pop;
  logic [1:0]         npush;

  assign push1     = c_fire & e1;
  assign push2     = c_fire & e2;
  assign npush     = {1'b0, push1} + {1'b0, push2};
  assign out_valid = (fcnt_r != '0);
  assign out_data  = fifo_q[rd_ptr_r];
  assign pop       = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (push1) begin
      fifo_q[wr_ptr_r] <= seg1;
    end
    if (push2) begin
      fifo_q[push1 ? (wr_ptr_r + FIFO_AW'(1)) : wr_ptr_r] <= seg2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fcnt_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + FIFO_AW'(npush);
      rd_ptr_r <= rd_ptr_r + FIFO_AW'(pop);
      fcnt_r   <= fcnt_r + FCNT_W'(npush) - FCNT_W'(pop);
    end
  end

`ifndef SYNTHESIS
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= FCNT_W'(FIFO_DEPTH))
    else $error("output queue overfilled");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (fcnt_r == '0) |-> !in_stall)
    else $error("input held while output queue is empty");

  a_tok_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.end_of_path) |=>
      (flags_r == '0 && int_r == '0 && frac_r == '0 && dcnt_r == '0))
    else $error("tokenizer state not cleared after end of path");

  a_cmd_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (c_fire && b2_r.last) |=> (cmd_r == CMD_NONE && ncnt_r == 2'd0))
    else $error("command state not cleared after end of path");

  a_ncnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    ncnt_r <= 2'd2)
    else $error("number count beyond two");
`endif

endmodule

`default_nettype wire

// ===== bench/svg_path_line_tokenizer_check.sv =====
`default_nettype none

module svg_path_line_tokenizer_check
  import svgplt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_stall,
  input  wire tok_in_t  in_data,
  input  wire logic     out_valid,
  input  wire logic     out_stall,
  input  wire seg_out_t out_data,
  output int            fail_count,
  output int            pending_segs
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;
  localparam int unsigned        INT_SAT = (1 << INT_W) - 1;

  // Shadow copy of the tokenizer state.
  logic [7:0]         cmd;
  logic signed [31:0] cur_x, cur_y, start_x, start_y;
  int unsigned        int_acc, frac_acc, frac_count;
  tok_flags_t         tok;
  int unsigned        num_count;
  logic signed [31:0] num_a, num_b;

  seg_out_t awaited_segs[$];
  seg_out_t byte_segs[$];
  int       errors = 0;

  function automatic void reset_path_state();
    cmd        = CMD_NONE;
    cur_x      = '0;
    cur_y      = '0;
    start_x    = '0;
    start_y    = '0;
    int_acc    = 0;
    frac_acc   = 0;
    frac_count = 0;
    tok        = '0;
    num_count  = 0;
    num_a      = '0;
    num_b      = '0;
  endfunction

  function automatic logic signed [31:0] sat_add(logic signed [31:0] a, logic signed [31:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > longint'(Q_MAX)) return Q_MAX;
    if (s < longint'(Q_MIN)) return Q_MIN;
    return 32'(s);
  endfunction

  // Converts the collected digits to Q16.16 and files the number, if valid.
  function automatic void finish_number();
    longint unsigned scale, mag;
    logic signed [31:0] v;
    if (tok.in_tok && tok.dig && !tok.bad) begin
      scale = 1;
      for (int i = 0; i < frac_count; i++) scale = scale * 10;
      mag = (64'(int_acc) << 16) +
            ((64'(frac_acc) * 64'd65536 + scale / 2) / scale);
      if (tok.neg) v = (mag >= 64'h8000_0000) ? Q_MIN : -$signed(mag[31:0]);
      else         v = (mag > 64'h7FFF_FFFF) ? Q_MAX : $signed(mag[31:0]);
      if (num_count == 0) num_a = v;
      else if (num_count == 1) num_b = v;
      if (num_count < 2) num_count++;
    end
    tok        = '0;
    int_acc    = 0;
    frac_acc   = 0;
    frac_count = 0;
  endfunction

  function automatic void emit_line(logic signed [31:0] tx, logic signed [31:0] ty);
    seg_out_t s;
    s.x_from      = cur_x;
    s.y_from      = cur_y;
    s.x_to        = tx;
    s.y_to        = ty;
    s.last_of_run = 1'b0;
    byte_segs     = {byte_segs, s};
    cur_x = tx;
    cur_y = ty;
  endfunction

  function automatic void act_on_command();
    case (cmd)
      CH_M: begin
        if (num_count >= 2) begin
          cur_x   = num_a;
          cur_y   = num_b;
          start_x = num_a;
          start_y = num_b;
        end
      end
      CH_L:  if (num_count >= 2) emit_line(num_a, num_b);
      CH_H:  if (num_count >= 1) emit_line(num_a, cur_y);
      CH_V:  if (num_count >= 1) emit_line(cur_x, num_a);
      CH_LH: if (num_count >= 1) emit_line(sat_add(cur_x, num_a), cur_y);
      CH_LV: if (num_count >= 1) emit_line(cur_x, sat_add(cur_y, num_a));
      CH_Z, CH_LZ: emit_line(start_x, start_y);
      default: ;
    endcase
    num_count = 0;
    num_a     = '0;
    num_b     = '0;
  endfunction

  function automatic void predict_segments(tok_in_t it);
    logic [7:0]  b;
    int unsigned d, t;
    b = it.path_byte;
    byte_segs.delete();
    if ((b >= CH_UA && b <= CH_Z) || (b >= CH_LA && b <= CH_LZ)) begin
      finish_number();
      act_on_command();
      cmd = b;
    end else if (b == CH_MINUS || b == CH_PLUS) begin
      finish_number();
      tok.in_tok = 1'b1;
      tok.neg    = (b == CH_MINUS);
    end else if (b >= CH_0 && b <= CH_9) begin
      d = b - CH_0;
      tok.in_tok = 1'b1;
      tok.dig    = 1'b1;
      if (tok.dot) begin
        if (frac_count < FRAC_DIGITS) begin
          frac_acc = frac_acc * 10 + d;
          frac_count++;
        end
      end else begin
        t = int_acc * 10 + d;
        int_acc = (t > INT_SAT) ? INT_SAT : t;
      end
    end else if (b == CH_DOT) begin
      if (tok.dot) tok.bad = 1'b1;
      tok.in_tok = 1'b1;
      tok.dot    = 1'b1;
    end else begin
      finish_number();
    end
    if (it.end_of_path) begin
      finish_number();
      act_on_command();
      reset_path_state();
    end
    if (byte_segs.size() > 0) byte_segs[byte_segs.size() - 1].last_of_run = 1'b1;
    awaited_segs = {awaited_segs, byte_segs};
  endfunction

  function automatic bit same_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d (%h), actual %0d (%h)", $time, name,
               $signed(want), want, $signed(got), got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void check_segment(seg_out_t got);
    seg_out_t want;
    bit ok;
    if (awaited_segs.size() == 0) begin
      $display("%0t: segment with none expected, expected nothing, actual %h", $time, got);
      errors++;
      return;
    end
    want = awaited_segs.pop_front();
    ok = same_field("x_from", want.x_from, got.x_from);
    ok &= same_field("y_from", want.y_from, got.y_from);
    ok &= same_field("x_to", want.x_to, got.x_to);
    ok &= same_field("y_to", want.y_to, got.y_to);
    ok &= same_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
    if (!ok) errors++;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_path_state();
      awaited_segs.delete();
    end else begin
      // A result never leaves in the cycle its item enters, so checking first is safe.
      if (out_valid && !out_stall) check_segment(out_data);
      if (in_valid && !in_stall) predict_segments(in_data);
    end
    fail_count   <= errors;
    pending_segs <= awaited_segs.size();
  end

endmodule

`default_nettype wire

// ===== bench/svg_path_line_tokenizer_test.sv =====
`default_nettype none

module svg_path_line_tokenizer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import svgplt_pkg::*;

  // Separator bytes that the package has no name for.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  localparam logic [7:0] KNOWN_CMDS [8] = '{CH_M, CH_L, CH_H, CH_V, CH_LH, CH_LV, CH_Z, CH_LZ};

  // Roughly how many random path bytes to send, and where the idling stops.
  localparam int RANDOM_BYTES = 1450;
  localparam int QUIET_FROM   = 1250;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  tok_in_t  in_data   = '0;
  logic     in_stall;
  logic     out_valid;
  logic     out_stall = 1'b0;
  seg_out_t out_data;
  int       fail_total;
  int       pending_segs;

  // Once set, neither side idles any more.
  bit quiet       = 1'b0;
  // Set for whole paths, so that some paths go through without sender gaps.
  bit sender_calm = 1'b0;

  logic [7:0] path_text[$];
  int         random_sent = 0;

  svg_path_line_tokenizer u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  svg_path_line_tokenizer_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .fail_count  (fail_total),
    .pending_segs(pending_segs)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver alternates between stalled bursts and free stretches, some of
  // them long, so that stalls land on every pipeline phase and also let the
  // output queue fill up and hold the pipeline back.
  int  burst_left = 0;
  bit  stall_now  = 1'b0;

  always @(negedge clk) begin
    if (quiet || !rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (burst_left == 0) begin
        stall_now  = ($urandom_range(0, 2) == 0);
        burst_left = stall_now ? $urandom_range(1, 19) :
                     (($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) :
                                                    $urandom_range(1, 20));
      end
      burst_left--;
      out_stall <= stall_now;
    end
  end

  // Offers one byte at the falling edge and waits until a rising edge takes it.
  // The task always returns at a falling edge, so the next byte, or a gap,
  // is set up in that time step.
  task automatic send_byte(logic [7:0] b, logic fin);
    if (!quiet && !sender_calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{path_byte: b, end_of_path: fin};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text(string s, bit fin);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fin && (i == s.len() - 1));
  endtask

  task automatic send_path();
    foreach (path_text[i]) send_byte(path_text[i], i == path_text.size() - 1);
  endtask

  // Appends one byte to the path being built.
  function automatic void add_byte(logic [7:0] c);
    path_text = {path_text, c};
  endfunction

  function automatic logic [7:0] any_digit();
    return CH_0 + 8'($urandom_range(0, 9));
  endfunction

  // One number token: optional sign, mostly short integer parts with the odd
  // saturating one, sometimes a fraction longer than the kept digits, and now
  // and then a broken token (no digits at all, or a second dot).
  function automatic void add_number();
    int r;
    int nint;
    int nfrac;
    r = $urandom_range(0, 5);
    if (r == 0) add_byte(CH_MINUS);
    else if (r == 1) add_byte(CH_PLUS);
    r = $urandom_range(0, 19);
    nint = (r == 0) ? 0 : (r < 14) ? $urandom_range(1, 2) : (r < 18) ? 3 : $urandom_range(4, 6);
    repeat (nint) add_byte(any_digit());
    if ($urandom_range(0, 2) == 0) begin
      add_byte(CH_DOT);
      nfrac = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 3);
      repeat (nfrac) add_byte(any_digit());
      if ($urandom_range(0, 19) == 0) begin
        add_byte(CH_DOT);
        add_byte(any_digit());
      end
    end
  endfunction

  // Mostly spaces and commas; sometimes nothing, so that tokens run together,
  // and sometimes a byte of any value at all.
  function automatic void add_separator();
    int r;
    r = $urandom_range(0, 19);
    if (r < 11) add_byte(CH_SPACE);
    else if (r < 16) add_byte(CH_COMMA);
    else if (r >= 18) add_byte(8'($urandom_range(0, 255)));
  endfunction

  // Usually the count that the command needs, sometimes one short, one over or any up to three.
  function automatic void add_numbers(int need);
    int r;
    int n;
    r = $urandom_range(0, 9);
    n = (r < 7) ? need : (r == 7) ? ((need > 0) ? need - 1 : 0) :
        (r == 8) ? need + 1 : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) add_byte(CH_SPACE);
    repeat (n) begin
      add_number();
      add_separator();
    end
  endfunction

  // Builds one path into path_text. Most paths are a move, left out now and then,
  // then a handful of drawing commands with their numbers. A few are pure noise.
  function automatic void build_path();
    int         ncmd;
    int         need;
    logic [7:0] c;
    path_text.delete();
    if ($urandom_range(0, 11) == 0) begin
      repeat ($urandom_range(1, 10)) add_byte(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 4) != 0) begin
      add_byte(CH_M);
      add_numbers(2);
    end
    ncmd = $urandom_range(1, 7);
    repeat (ncmd) begin
      if ($urandom_range(0, 15) == 0)
        c = ($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'($urandom_range(0, 25));
      else
        c = KNOWN_CMDS[$urandom_range(0, 7)];
      add_byte(c);
      case (c)
        CH_M, CH_L:  need = 2;
        CH_Z, CH_LZ: need = 0;
        default:     need = 1;
      endcase
      add_numbers(need);
    end
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed paths. The first has numbers before any letter, a sign that
    // splits a number, a negative and a positive integer part that saturate,
    // an L with too few numbers, h sums that stay in range and one that does
    // not, a number with two dots, a V with nothing to act on, and a close
    // that the end of the path carries out.
    send_text("1-.5M-99999 2L7h99999h1h99999V.1.2z", 1'b1);
    // Fraction digits past the kept ones, a third number after L, and an end
    // byte that both finishes the pending H and closes the path: two segments.
    send_text("L.0000099 1 2H3Z", 1'b1);
    // A close with no move before it, a stray all-ones byte as a separator,
    // and an unknown letter that only ends the pending command.
    send_text("Zv-3", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("Q", 1'b1);
    // A zero byte as separator, and a path that ends on a digit.
    send_byte(8'h00, 1'b0);
    send_text("M4,5L6 7", 1'b1);

    while (random_sent < RANDOM_BYTES) begin
      if (random_sent >= QUIET_FROM) quiet = 1'b1;
      sender_calm = ($urandom_range(0, 3) == 0);
      build_path();
      send_path();
      random_sent += path_text.size();
    end
    in_valid <= 1'b0;

    // Let every expected segment arrive, then give the pipeline time to show
    // any segment that nothing asked for.
    while (pending_segs != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (fail_total == 0) begin
      $display("svg_path_line_tokenizer_test passed");
    end else begin
      $display("svg_path_line_tokenizer_test failed");
    end
    $finish;
  end

  // Several times the slowest correct run: every byte behind a long sender gap
  // and every segment behind a long receiver stall.
  initial begin
    #5_000_000;
    $display("svg_path_line_tokenizer_test failed");
    $finish;
  end

endmodule

`default_nettype wire
